### hdl/ic3_pkg.sv
// Shared types, codes and kernel coefficients for the 3x3 image convolution block.
package ic3_pkg;

    localparam int DefaultMaxWidth = 4096;
    localparam int MaxChannels     = 4;
    localparam int MaxHeight       = 4096;
    localparam int PosW            = 12;
    localparam int CfgW            = 13;

    localparam logic [CfgW-1:0] WidthReset   = 13'd640;
    localparam logic [CfgW-1:0] HeightReset  = 13'd480;
    localparam logic [2:0]      ChannelReset = 3'd3;

    typedef enum logic [1:0] {
        CFG_WIDTH    = 2'd0,
        CFG_HEIGHT   = 2'd1,
        CFG_CHANNELS = 2'd2,
        CFG_KERNEL   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        K_EDGE     = 3'd0,
        K_SHARPEN  = 3'd1,
        K_BOX      = 3'd2,
        K_GAUSS    = 3'd3,
        K_EMBOSS   = 3'd4,
        K_IDENTITY = 3'd5
    } kernel_t;

    // Position of one input pixel and the edge facts the sequencer needs.
    typedef struct packed {
        logic [PosW-1:0] col;
        logic [PosW-1:0] row;
        logic            first_c;
        logic            second_c;
        logic            last_c;
        logic            first_r;
        logic            second_r;
        logic            last_r;
    } ic3_pos_t;

    // Q4.12 coefficients, row-major within the window.
    function automatic logic signed [15:0] kernel_coef(input logic [2:0] k, input int i);
        logic signed [15:0] c;
        c = 16'sd0;
        unique case (k)
            K_EDGE: c = (i == 4) ? 16'sd16384 :
                        (i == 1 || i == 3 || i == 5 || i == 7) ? -16'sd4096 : 16'sd0;
            K_SHARPEN: c = (i == 4) ? 16'sd20480 :
                        (i == 1 || i == 3 || i == 5 || i == 7) ? -16'sd4096 : 16'sd0;
            K_BOX: c = 16'sd455;
            K_GAUSS: c = (i == 4) ? 16'sd1024 :
                        (i == 1 || i == 3 || i == 5 || i == 7) ? 16'sd512 : 16'sd256;
            K_EMBOSS: c = (i == 0) ? -16'sd8192 :
                        (i == 1 || i == 3) ? -16'sd4096 :
                        (i == 4 || i == 5 || i == 7) ? 16'sd4096 :
                        (i == 8) ? 16'sd8192 : 16'sd0;
            default: c = (i == 4) ? 16'sd4096 : 16'sd0;
        endcase
        return c;
    endfunction

endpackage

### hdl/ic3_front.sv
// Input stage: raster counters, the two line stores and the fetched column.
module ic3_front #(
    parameter int MAX_WIDTH = ic3_pkg::DefaultMaxWidth
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [31:0]             s_axis_tdata,
    input  logic [ic3_pkg::CfgW-1:0] image_width,
    input  logic [ic3_pkg::CfgW-1:0] image_height,
    input  logic                    move,
    output logic                    item_valid,
    output ic3_pkg::ic3_pos_t       item_pos,
    output logic [31:0]             item_pix,
    output logic [31:0]             item_up,
    output logic [31:0]             item_mid
);
    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = (XW + 1 > ic3_pkg::CfgW) ? XW + 1 : ic3_pkg::CfgW;

    logic [31:0] upper_mem  [MAX_WIDTH];
    logic [31:0] middle_mem [MAX_WIDTH];

    logic [XW-1:0]  x_reg, x_next;
    logic [11:0]    y_reg, y_next;
    logic [XW-1:0]  xi_reg;
    logic           valid_reg;
    ic3_pkg::ic3_pos_t pos_reg;
    logic [31:0]    pix_reg, up_rd_reg, mid_rd_reg, fwd_data_reg;
    logic           fwd_reg;

    logic [WW-1:0]  w_eff, x_ext;
    logic [12:0]    h_eff, y_ext;
    logic           accept, last_c, last_r;

    assign s_axis_tready = !valid_reg || move;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (image_width == '0)
            w_eff = WW'(1);
        else if (WW'(image_width) > WW'(MAX_WIDTH))
            w_eff = WW'(MAX_WIDTH);
        else
            w_eff = WW'(image_width);
        if (image_height == '0)
            h_eff = 13'd1;
        else if (image_height > 13'(ic3_pkg::MaxHeight))
            h_eff = 13'(ic3_pkg::MaxHeight);
        else
            h_eff = image_height;
        x_ext  = WW'(x_reg);
        y_ext  = 13'(y_reg);
        last_c = x_ext >= w_eff - WW'(1);
        last_r = y_ext >= h_eff - 13'd1;
        x_next = x_reg;
        y_next = y_reg;
        if (last_c)
        begin
            x_next = '0;
            y_next = last_r ? 12'd0 : y_reg + 12'd1;
        end
        else
        begin
            x_next = x_reg + XW'(1);
        end
    end

    // Line stores: the middle row is rewritten on arrival, the upper row when
    // the fetched column leaves for the window.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg  <= upper_mem[x_reg];
            mid_rd_reg <= middle_mem[x_reg];
            middle_mem[x_reg] <= s_axis_tdata;
            pix_reg <= s_axis_tdata;
            xi_reg  <= x_reg;
            fwd_data_reg <= mid_rd_reg;
            pos_reg <= '{col: 12'(x_reg), row: y_reg,
                         first_c: x_reg == '0, second_c: x_reg == XW'(1), last_c: last_c,
                         first_r: y_reg == '0, second_r: y_reg == 12'd1, last_r: last_r};
        end
        if (move)
            upper_mem[xi_reg] <= mid_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg     <= '0;
            y_reg     <= '0;
            valid_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                // The upper write of the leaving column lands too late for this read.
                fwd_reg <= move && (xi_reg == x_reg);
            end
            if (accept)
                valid_reg <= 1'b1;
            else if (move)
                valid_reg <= 1'b0;
        end
    end

    assign item_valid = valid_reg;
    assign item_pos   = pos_reg;
    assign item_pix   = pix_reg;
    assign item_up    = fwd_reg ? fwd_data_reg : up_rd_reg;
    assign item_mid   = mid_rd_reg;
endmodule

### hdl/ic3_lane.sv
// One channel lane: nine-tap weighted sum of the selected window bytes.
module ic3_lane (
    input  logic               clk,
    input  logic               en,
    input  logic [2:0]         kernel_select,
    input  logic [7:0]         taps [9],
    output logic signed [31:0] sum
);
    logic signed [31:0] sum_reg, sum_next;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < 9; i++)
            sum_next = sum_next + 32'(ic3_pkg::kernel_coef(kernel_select, i)) *
                                  32'($signed({1'b0, taps[i]}));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sum_reg <= sum_next;
    end

    assign sum = sum_reg;
endmodule

### hdl/ic3_merge.sv
// Merge of the lane sums: scaling, saturation and masking of idle channels.
module ic3_merge (
    input  logic signed [31:0] sums [4],
    input  logic [2:0]         channel_count,
    output logic [31:0]        pixel
);
    logic [2:0]         nch;
    logic signed [31:0] q;

    always_comb
    begin
        if (channel_count == 3'd0)
            nch = 3'd1;
        else if (channel_count > 3'(ic3_pkg::MaxChannels))
            nch = 3'(ic3_pkg::MaxChannels);
        else
            nch = channel_count;
        pixel = '0;
        q = '0;
        for (int ch = 0; ch < 4; ch++)
        begin
            q = sums[ch] >>> 12;
            if (3'(ch) >= nch || sums[ch] <= 0)
                pixel[8*ch +: 8] = 8'd0;
            else if (q > 255)
                pixel[8*ch +: 8] = 8'd255;
            else
                pixel[8*ch +: 8] = q[7:0];
        end
    end
endmodule

### hdl/image_conv3x3_clamped.sv
// Streaming 3x3 convolution with edge clamping. Pixels of up to four 8-bit
// channels enter in raster order, one per clock while the output is not stalled
// and no pixel owes more than one result; each accepted pixel releases zero to
// four filtered pixels (the one above and left of it, and at the right or bottom
// edge also the edge pixels), issued one at a time by the single result sequencer
// that walks the 3x3 window; results then pass the cell, sum and output registers.
// The two line stores hold MAX_WIDTH pixels each and need no clearing after reset.
// Configuration writes are taken at any time but belong between frames.
module image_conv3x3_clamped #(
    parameter int MAX_WIDTH = ic3_pkg::DefaultMaxWidth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // sample_c0, sample_c1, sample_c2, sample_c3
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // result_c0..result_c3, out_col, out_row
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);
    logic [12:0] width_reg, height_reg;
    logic [2:0]  channels_reg, kernel_reg;

    logic              item_valid, move, en, issue, last_res;
    ic3_pkg::ic3_pos_t item_pos, pos_reg;
    logic [31:0]       item_pix, item_up, item_mid;
    logic [31:0]       win_reg [9];
    logic              pend_reg, a_reg, b_reg;
    logic              col_prev, row_prev, final_col, final_row;
    logic [1:0]        colsel [3];
    logic [1:0]        rowsel [3];
    logic [11:0]       res_col, res_row;

    logic [31:0]       p1_cells_reg [9];
    logic [11:0]       p1_col_reg, p1_row_reg, p2_col_reg, p2_row_reg;
    logic              p1_last_reg, p2_last_reg, p1_valid_reg, p2_valid_reg;
    logic signed [31:0] sums [4];
    logic [31:0]       merged;
    logic [55:0]       out_data_reg;
    logic              out_valid_reg, out_last_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= ic3_pkg::WidthReset;
            height_reg   <= ic3_pkg::HeightReset;
            channels_reg <= ic3_pkg::ChannelReset;
            kernel_reg   <= ic3_pkg::K_IDENTITY;
        end
        else if (cfg_valid)
        begin
            unique case (ic3_pkg::cfg_index_t'(cfg_index))
                ic3_pkg::CFG_WIDTH:    width_reg    <= cfg_data;
                ic3_pkg::CFG_HEIGHT:   height_reg   <= cfg_data;
                ic3_pkg::CFG_CHANNELS: channels_reg <= cfg_data[2:0];
                ic3_pkg::CFG_KERNEL:   kernel_reg   <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    ic3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .image_width(width_reg), .image_height(height_reg), .move,
        .item_valid, .item_pos, .item_pix, .item_up, .item_mid
    );

    assign en = !out_valid_reg || m_axis_tready;

    // Result sequencer: columns outer, rows inner, as a pixel completes them.
    always_comb
    begin
        col_prev  = !a_reg && !pos_reg.first_c;
        row_prev  = !b_reg && !pos_reg.first_r;
        final_col = col_prev ? !pos_reg.last_c : 1'b1;
        final_row = row_prev ? !pos_reg.last_r : 1'b1;
        last_res  = final_col && final_row;
        if (col_prev)
        begin
            colsel[0] = pos_reg.second_c ? 2'd1 : 2'd0;
            colsel[1] = 2'd1;
            colsel[2] = 2'd2;
            res_col   = pos_reg.col - 12'd1;
        end
        else
        begin
            colsel[0] = pos_reg.first_c ? 2'd2 : 2'd1;
            colsel[1] = 2'd2;
            colsel[2] = 2'd2;
            res_col   = pos_reg.col;
        end
        if (row_prev)
        begin
            rowsel[0] = pos_reg.second_r ? 2'd1 : 2'd0;
            rowsel[1] = 2'd1;
            rowsel[2] = 2'd2;
            res_row   = pos_reg.row - 12'd1;
        end
        else
        begin
            rowsel[0] = pos_reg.first_r ? 2'd2 : 2'd1;
            rowsel[1] = 2'd2;
            rowsel[2] = 2'd2;
            res_row   = pos_reg.row;
        end
    end

    assign issue = pend_reg && en;
    assign move  = item_valid && (!pend_reg || (issue && last_res));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
            a_reg    <= 1'b0;
            b_reg    <= 1'b0;
            pos_reg  <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            if (move)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= item_up;
                win_reg[5] <= item_mid;
                win_reg[8] <= item_pix;
                pos_reg  <= item_pos;
                pend_reg <= (!item_pos.first_c || item_pos.last_c) &&
                            (!item_pos.first_r || item_pos.last_r);
                a_reg <= 1'b0;
                b_reg <= 1'b0;
            end
            else if (issue)
            begin
                if (final_row)
                begin
                    b_reg <= 1'b0;
                    if (final_col)
                        pend_reg <= 1'b0;
                    else
                        a_reg <= 1'b1;
                end
                else
                begin
                    b_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
                for (int c = 0; c < 3; c++)
                    p1_cells_reg[r*3+c] <= win_reg[4'(rowsel[r]) * 4'd3 + 4'(colsel[c])];
            p1_col_reg  <= res_col;
            p1_row_reg  <= res_row;
            p1_last_reg <= last_res;
            p2_col_reg  <= p1_col_reg;
            p2_row_reg  <= p1_row_reg;
            p2_last_reg <= p1_last_reg;
            out_data_reg <= {p2_row_reg, p2_col_reg, merged};
            out_last_reg <= p2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg  <= issue;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    for (genvar ch = 0; ch < 4; ch++)
    begin : g_lane
        logic [7:0] taps [9];
        always_comb
        begin
            for (int i = 0; i < 9; i++)
                taps[i] = p1_cells_reg[i][8*ch +: 8];
        end
        ic3_lane u_lane (
            .clk, .en, .kernel_select(kernel_reg), .taps, .sum(sums[ch])
        );
    end

    ic3_merge u_merge (.sums, .channel_count(channels_reg), .pixel(merged));

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef ASSERT_OFF
    a_second_col: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && a_reg |-> !pos_reg.first_c && pos_reg.last_c)
        else $error("sequencer on a second column that does not exist");
    a_second_row: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && b_reg |-> !pos_reg.first_r && pos_reg.last_r)
        else $error("sequencer on a second row that does not exist");
    a_hold_window: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !issue |=> $stable(pend_reg) && $stable(a_reg) && $stable(b_reg))
        else $error("sequencer advanced while the pipeline was stalled");
`endif
endmodule
